// ===== hw/rtl/pc_pkg.sv =====
// path canonicaliser package: character codes, field widths, sequencer states
// no dependencies; imported by the interfaces, the top level and the checker
package pc_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_OUT_W = 9;

  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

  localparam logic OP_PATH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] CHARS_ONE  = 2'd1;
  localparam logic [1:0] CHARS_TWO  = 2'd2;
  localparam logic [1:0] CHARS_SAT  = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b000_0001,
    ST_PATH   = 7'b000_0010,
    ST_CHAR   = 7'b000_0100,
    ST_CLOSE  = 7'b000_1000,
    ST_POP    = 7'b001_0000,
    ST_FINAL  = 7'b010_0000,
    ST_RESULT = 7'b100_0000
  } state_t;

endpackage

// ===== hw/rtl/pc_req_if.sv =====
// request channel of the path canonicaliser: valid/ready plus request fields
// depends on pc_pkg for field widths
interface pc_req_if import pc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] path_byte;
  logic              final_byte;
  logic [BYTE_W-1:0] read_index;

  modport source (output valid, output opcode, output path_byte, output final_byte,
                  output read_index, input ready);
  modport sink   (input valid, input opcode, input path_byte, input final_byte,
                  input read_index, output ready);
endinterface

// ===== hw/rtl/pc_rsp_if.sv =====
// result channel of the path canonicaliser: valid/ready plus result fields
// depends on pc_pkg for field widths
interface pc_rsp_if import pc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 is_read_reply;
  logic [BYTE_W-1:0]    out_byte;
  logic [LEN_OUT_W-1:0] canonical_length;
  logic                 overflow;

  modport source (output valid, output is_read_reply, output out_byte,
                  output canonical_length, output overflow, input ready);
  modport sink   (input valid, input is_read_reply, input out_byte,
                  input canonical_length, input overflow, output ready);
endinterface

// ===== hw/rtl/path_canonicalizer.sv =====
// steps: a read request goes through the result step to the output register; a path byte
// through the path step, then the char or close step and a possible pop; a final byte on
// through the final and result steps to its end-of-path report; a new request is taken
// only when the sequencer, which drives the single write ports of store and stack, is idle
// reset: synchronous, clears the sequencer, lengths, counters and flags; the two
// memories are not cleared and need no clearing pass (reads never pass the length)
module path_canonicalizer import pc_pkg::*; #(
  parameter int BUF_BYTES    = 256,
  parameter int MAX_SEGMENTS = 128
) (
  input  logic      clk,
  input  logic      rst,
  pc_req_if.sink    req,
  pc_rsp_if.source  rsp
);

  localparam int ADDR_W = $clog2(BUF_BYTES);
  localparam int LEN_W  = $clog2(BUF_BYTES + 1);
  localparam int SP_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int CMP_W  = (LEN_W > BYTE_W) ? LEN_W : BYTE_W;

  // sequencer and latched request
  state_t            state;
  logic              op;
  logic [BYTE_W-1:0] byte_q;
  logic              fin_q;
  logic [BYTE_W-1:0] idx_q;

  // path state: output length, stack depth, current segment shape
  logic [LEN_W-1:0]  len;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        chars;
  logic              all_dots;
  logic              in_seg;
  logic              ovf;
  logic              done;

  // output store: canonical bytes, one write port, one registered read port
  logic [BYTE_W-1:0] store [BUF_BYTES];
  logic [BYTE_W-1:0] store_rdata;
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [BYTE_W-1:0] st_wdata;

  // segment stack: output length at the start of each kept segment
  logic [LEN_W-1:0]  stack [MAX_SEGMENTS];
  logic [LEN_W-1:0]  stack_rdata;
  logic              push_en;
  logic              pop_needed;
  logic              pop_two;
  logic [CNT_W-1:0]  cnt_dec;

  logic              len_ok;
  logic              accept;
  logic              slot_free;
  logic [CMP_W-1:0]  req_idx_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  len_ext;
  logic              rd_hit;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !rsp.valid || rsp.ready;

  // room for one more byte in the store
  assign len_ok = (len < LEN_W'(BUF_BYTES));

  // a new segment starts: remember where its slash goes, if the stack has room
  assign push_en = (state == ST_PATH) && (byte_q != CH_SLASH) && !in_seg &&
                   (cnt < CNT_W'(MAX_SEGMENTS));

  // closing '.' pops once, closing '..' pops twice; only the last popped start matters
  assign pop_needed = in_seg && all_dots && (chars == CHARS_ONE || chars == CHARS_TWO) &&
                      (cnt != '0);
  assign pop_two    = (chars == CHARS_TWO) && (cnt >= CNT_W'(2));
  assign cnt_dec    = pop_two ? (cnt - CNT_W'(2)) : (cnt - CNT_W'(1));

  // store write selection: leading slash, segment byte, or lone root slash
  always_comb begin
    st_we    = 1'b0;
    st_waddr = len[ADDR_W-1:0];
    st_wdata = byte_q;
    unique case (state)
      ST_PATH: begin
        st_we    = (byte_q != CH_SLASH) && !in_seg && len_ok;
        st_wdata = CH_SLASH;
      end
      ST_CHAR: begin
        st_we    = len_ok;
      end
      ST_FINAL: begin
        st_we    = (len == '0);
        st_waddr = '0;
        st_wdata = CH_SLASH;
      end
      default: begin
        st_we    = 1'b0;
      end
    endcase
  end

  // read hit: inside the current length and inside the store
  assign req_idx_ext = CMP_W'(req.read_index);
  assign idx_ext     = CMP_W'(idx_q);
  assign len_ext     = CMP_W'(len);
  assign rd_hit      = (idx_ext < len_ext) && (idx_ext < CMP_W'(BUF_BYTES));

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    if (accept && req.opcode == OP_READ && req_idx_ext < CMP_W'(BUF_BYTES)) begin
      store_rdata <= store[req_idx_ext[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack[cnt[SP_W-1:0]] <= len;
    end
    if (state == ST_CLOSE && pop_needed) begin
      stack_rdata <= stack[cnt_dec[SP_W-1:0]];
    end
  end

  // latched request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.opcode;
      byte_q <= req.path_byte;
      fin_q  <= req.final_byte;
      idx_q  <= req.read_index;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      len      <= '0;
      cnt      <= '0;
      chars    <= '0;
      all_dots <= 1'b1;
      in_seg   <= 1'b0;
      ovf      <= 1'b0;
      done     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.opcode == OP_READ) begin
              // store read issued this edge, data ready in the result step
              state <= ST_RESULT;
            end else begin
              // first byte after a finished path starts a fresh one
              if (done) begin
                len  <= '0;
                ovf  <= 1'b0;
                done <= 1'b0;
              end
              state <= ST_PATH;
            end
          end
        end
        ST_PATH: begin
          if (byte_q == CH_SLASH) begin
            state <= ST_CLOSE;
          end else begin
            if (!in_seg) begin
              if (push_en) begin
                cnt <= cnt + CNT_W'(1);
              end
              if (len_ok) begin
                len <= len + LEN_W'(1);
              end
              // stack full or store full
              if (!push_en || !len_ok) begin
                ovf <= 1'b1;
              end
              in_seg   <= 1'b1;
              chars    <= '0;
              all_dots <= 1'b1;
            end
            state <= ST_CHAR;
          end
        end
        ST_CHAR: begin
          if (len_ok) begin
            len <= len + LEN_W'(1);
          end else begin
            ovf <= 1'b1;
          end
          if (chars != CHARS_SAT) begin
            chars <= chars + 2'd1;
          end
          if (byte_q != CH_DOT) begin
            all_dots <= 1'b0;
          end
          state <= fin_q ? ST_CLOSE : ST_IDLE;
        end
        ST_CLOSE: begin
          in_seg   <= 1'b0;
          chars    <= '0;
          all_dots <= 1'b1;
          if (pop_needed) begin
            cnt   <= cnt_dec;
            state <= ST_POP;
          end else begin
            state <= fin_q ? ST_FINAL : ST_IDLE;
          end
        end
        ST_POP: begin
          len   <= stack_rdata;
          state <= fin_q ? ST_FINAL : ST_IDLE;
        end
        ST_FINAL: begin
          // empty result is the root alone
          if (len == '0) begin
            len <= LEN_W'(1);
          end
          cnt   <= '0;
          done  <= 1'b1;
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register: parts the result from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_RESULT && slot_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && slot_free) begin
      rsp.is_read_reply    <= op;
      rsp.out_byte         <= (op == OP_READ && rd_hit) ? store_rdata : '0;
      rsp.canonical_length <= LEN_OUT_W'(len);
      rsp.overflow         <= ovf;
    end
  end

endmodule

// ===== hw/rtl/pc_checker.sv =====
// port-level checks for the path canonicaliser, attached by bind
// depends on pc_pkg and on the top level's interface ports
module pc_checker import pc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic                 rsp_is_read_reply,
  input logic [BYTE_W-1:0]    rsp_out_byte,
  input logic [LEN_OUT_W-1:0] rsp_canonical_length,
  input logic                 rsp_overflow
);

  // no result left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // one request at a time: ready drops after each accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one in progress");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_is_read_reply) &&
      $stable(rsp_out_byte) && $stable(rsp_canonical_length) && $stable(rsp_overflow)))
    else $error("stalled result changed");

  // end-of-path reports carry no byte
  a_report_byte: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_is_read_reply) |-> (rsp_out_byte == '0))
    else $error("end-of-path report with non-zero byte");

endmodule

bind path_canonicalizer pc_checker u_pc_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_is_read_reply    (rsp.is_read_reply),
  .rsp_out_byte         (rsp.out_byte),
  .rsp_canonical_length (rsp.canonical_length),
  .rsp_overflow         (rsp.overflow)
);
